### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the shader block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge out of reset.
`define PPLS_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("shader check failed");

// Checks that a consequent holds whenever an antecedent holds.
`define PPLS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shader check failed");

`endif

### hw/rtl/ppls_pkg.sv
// Shared constants, types and helpers of the point-light shader.
package ppls_pkg;

	// Vector format.
	localparam int COMPONENT_WIDTH = 21;
	localparam int VEC_W = 3 * COMPONENT_WIDTH;
	localparam int FRAC_IN = 10;
	localparam int SHININESS_LOG2_DEF = 6;

	// Normalize unit widths.
	localparam int DIFF_W = COMPONENT_WIDTH + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int SQRT_STEPS = DIFF_W;
	localparam int LEN_W = DIFF_W + 1;
	localparam int UNIT_SHIFT = 16;
	localparam int QUO_W = UNIT_SHIFT + 1;
	localparam int UNIT_W = QUO_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int NORM_LAT = 2 + SQRT_STEPS + DIV_STEPS + 1;

	// Color and accumulator widths.
	localparam int CH_W = 8;
	localparam int COLOR_W = 3 * CH_W;
	localparam int ACC_W = CH_W + 16;
	localparam logic [ACC_W-1:0] CH_MAX = ACC_W'(255) << 16;
	localparam int SPEC_W = 25;
	localparam logic [SPEC_W-1:0] SPEC_CAP = SPEC_W'(1) << 24;
	localparam int RATIO_W = 9;
	localparam int GAIN_W = 16;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LIGHT_POSITION = 2'd0;
	localparam reg_idx_t REG_LIGHT_RATIO = 2'd1;
	localparam reg_idx_t REG_LUMEN_GAIN = 2'd2;
	localparam reg_idx_t REG_LIGHT_ENABLE = 2'd3;

	// Item data that rides alongside the normalize units.
	typedef struct packed {
		logic bypass;
		logic [2:0][COMPONENT_WIDTH-1:0] nrm;
		logic [COLOR_W-1:0] amb;
		logic [COLOR_W-1:0] col;
	} side_t;

	// Item data that rides alongside the specular power chain.
	typedef struct packed {
		logic bypass;
		logic [COLOR_W-1:0] amb;
		logic [2:0][ACC_W-1:0] acc;
	} tail_t;

	// Register count from accepted item to result strobe.
	function automatic int pipe_latency(int shin);
		return 1 + NORM_LAT + 6 + shin + 4;
	endfunction

endpackage

### hw/rtl/phong_point_light_shader.sv
// Throughput: one item per clock; busy never rises and the pipeline never stalls.
// Latency is set by the two normalize units, which resolve one square-root bit
// and one quotient bit per stage, and by one squaring stage per shininess step.
// Reset clears all valid bits and loads the configuration register defaults.
module phong_point_light_shader
	import ppls_pkg::*;
#(
	parameter int SHININESS_LOG2 = SHININESS_LOG2_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic [VEC_W-1:0]     hit_point,
	input  logic [VEC_W-1:0]     surface_normal,
	input  logic [VEC_W-1:0]     view_ray_direction,
	input  logic [COLOR_W-1:0]   surface_color,
	input  logic [COLOR_W-1:0]   ambient_color,
	input  logic                 in_shadow,
	output logic                 done,
	output logic [CH_W-1:0]      red_out,
	output logic [CH_W-1:0]      green_out,
	output logic [CH_W-1:0]      blue_out
);

	localparam int DP_W = UNIT_W + COMPONENT_WIDTH;
	localparam int DSUM_W = DP_W + 2;
	localparam int D_W = DSUM_W - FRAC_IN;
	localparam int T_W = D_W + COMPONENT_WIDTH;
	localparam int R_W = T_W - (FRAC_IN - 1) + 1;
	localparam int M_W = UNIT_W + R_W;
	localparam int MSUM_W = M_W + 2;
	localparam int CD_W = CH_W + D_W - 1;
	localparam int DF_W = CD_W + RATIO_W - 8;
	localparam int SP_W = SPEC_W + CH_W - 1;
	localparam int G_W = ACC_W + GAIN_W;
	localparam int H_W = G_W + RATIO_W;

	// Configuration registers.
	logic [VEC_W-1:0]   light_position_q;
	logic [RATIO_W-1:0] light_ratio_q;
	logic [GAIN_W-1:0]  lumen_gain_q;
	logic               light_enable_q;
	reg_idx_t           reg_idx;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_position_q <= '0;
			light_ratio_q <= RATIO_W'(256);
			lumen_gain_q <= GAIN_W'(256);
			light_enable_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_LIGHT_POSITION: light_position_q <= pwdata[VEC_W-1:0];
				REG_LIGHT_RATIO: light_ratio_q <= pwdata[RATIO_W-1:0];
				REG_LUMEN_GAIN: lumen_gain_q <= pwdata[GAIN_W-1:0];
				REG_LIGHT_ENABLE: light_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read data.
	always_comb begin
		case (reg_idx)
			REG_LIGHT_POSITION: prdata = DATA_W'(light_position_q);
			REG_LIGHT_RATIO: prdata = DATA_W'(light_ratio_q);
			REG_LUMEN_GAIN: prdata = DATA_W'(lumen_gain_q);
			REG_LIGHT_ENABLE: prdata = DATA_W'(light_enable_q);
			default: prdata = '0;
		endcase
	end

	// Light and view vectors of the incoming item.
	logic [2:0][DIFF_W-1:0] lv_c, vv_c;
	for (genvar i = 0; i < 3; i++) begin : g_in
		assign lv_c[i] = DIFF_W'($signed(light_position_q[i*COMPONENT_WIDTH +: COMPONENT_WIDTH]))
			- DIFF_W'($signed(hit_point[i*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
		assign vv_c[i] = -DIFF_W'($signed(view_ray_direction[i*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
	end

	// Stage 1: input register.
	logic [2:0][DIFF_W-1:0] lv_s1, vv_s1;
	side_t                  side_s1;
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		lv_s1 <= lv_c;
		vv_s1 <= vv_c;
		side_s1.bypass <= !light_enable_q || in_shadow;
		side_s1.nrm <= surface_normal;
		side_s1.amb <= ambient_color;
		side_s1.col <= surface_color;
	end

	// Unit light and view vectors.
	logic [2:0][UNIT_W-1:0] ul_n, uv_n;

	ppls_norm u_norm_light (
		.clk   (clk),
		.v_in  (lv_s1),
		.u_out (ul_n)
	);

	ppls_norm u_norm_view (
		.clk   (clk),
		.v_in  (vv_s1),
		.u_out (uv_n)
	);

	// Item data delayed to match the normalize units.
	side_t side_s2 [NORM_LAT];
	logic  vld_s2 [NORM_LAT];

	always_ff @(posedge clk) begin
		side_s2[0] <= side_s1;
		for (int k = 1; k < NORM_LAT; k++) begin
			side_s2[k] <= side_s2[k-1];
		end
	end

	// Valid bits for the front of the pipeline.
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k < NORM_LAT; k++) begin
				vld_s2[k] <= 1'b0;
			end
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2[0] <= vld_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				vld_s2[k] <= vld_s2[k-1];
			end
			vld_s3 <= vld_s2[NORM_LAT-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Stage 3: light vector times normal, per component.
	logic signed [DP_W-1:0] dp_s3 [3];
	logic [2:0][UNIT_W-1:0] ul_s3, uv_s3, uv_s4, uv_s5, uv_s6;
	logic [2:0][UNIT_W-1:0] ul_s4, ul_s5;
	side_t                  side_s3, side_s4, side_s5, side_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dp_s3[i] <= $signed(ul_n[i]) * $signed(side_s2[NORM_LAT-1].nrm[i]);
		end
		ul_s3 <= ul_n;
		uv_s3 <= uv_n;
		side_s3 <= side_s2[NORM_LAT-1];
	end

	// Stage 4: light cosine.
	logic signed [DSUM_W-1:0] dsum_c;
	logic signed [D_W-1:0]    d_s4;

	assign dsum_c = DSUM_W'(dp_s3[0]) + DSUM_W'(dp_s3[1]) + DSUM_W'(dp_s3[2]);

	always_ff @(posedge clk) begin
		d_s4 <= dsum_c[DSUM_W-1:FRAC_IN];
		ul_s4 <= ul_s3;
		uv_s4 <= uv_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: cosine times normal for the reflection, color times cosine.
	logic signed [T_W-1:0] t_s5 [3];
	logic [CD_W-1:0]       cd_s5 [3];
	logic [D_W-2:0]        dpos_c;

	assign dpos_c = d_s4[D_W-1] ? '0 : d_s4[D_W-2:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s5[i] <= d_s4 * $signed(side_s4.nrm[i]);
			cd_s5[i] <= side_s4.col[i*CH_W +: CH_W] * dpos_c;
		end
		ul_s5 <= ul_s4;
		uv_s5 <= uv_s4;
		side_s5 <= side_s4;
	end

	// Stage 6: reflected light vector and diffuse term.
	logic signed [R_W-1:0] r_s6 [3];
	logic [DF_W-1:0]       diff_s6 [3];
	logic [CD_W+RATIO_W-1:0] cdr_c [3];

	for (genvar i = 0; i < 3; i++) begin : g_cdr
		assign cdr_c[i] = cd_s5[i] * light_ratio_q;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s6[i] <= R_W'((t_s5[i] >>> (FRAC_IN - 1)) - T_W'($signed(ul_s5[i])));
			diff_s6[i] <= cdr_c[i][CD_W+RATIO_W-1:8];
		end
		uv_s6 <= uv_s5;
		side_s6 <= side_s5;
	end

	// Stage 7: view vector times reflection, ambient plus diffuse.
	logic signed [M_W-1:0]   m_s7 [3];
	logic [DF_W:0]           a1_c [3];
	tail_t                   tail_s7, tail_s8;

	for (genvar i = 0; i < 3; i++) begin : g_a1
		assign a1_c[i] = (DF_W+1)'({side_s6.amb[i*CH_W +: CH_W], 16'd0}) + (DF_W+1)'(diff_s6[i]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s7[i] <= $signed(uv_s6[i]) * r_s6[i];
			tail_s7.acc[i] <= (a1_c[i] > (DF_W+1)'(CH_MAX)) ? CH_MAX : a1_c[i][ACC_W-1:0];
		end
		tail_s7.bypass <= side_s6.bypass;
		tail_s7.amb <= side_s6.amb;
	end

	// Stage 8: specular cosine, clamped.
	logic signed [MSUM_W-1:0] msum_c;
	logic [SPEC_W-1:0]        s_s8;

	assign msum_c = MSUM_W'(m_s7[0]) + MSUM_W'(m_s7[1]) + MSUM_W'(m_s7[2]);

	always_ff @(posedge clk) begin
		if (msum_c < 0) begin
			s_s8 <= '0;
		end else if (msum_c[MSUM_W-1:16] > (MSUM_W-16)'(SPEC_CAP)) begin
			s_s8 <= SPEC_CAP;
		end else begin
			s_s8 <= msum_c[16 +: SPEC_W];
		end
		tail_s8 <= tail_s7;
	end

	// Specular power: one squaring per stage.
	logic [SPEC_W-1:0] sh_s [SHININESS_LOG2+1];
	tail_t             tail_sh [SHININESS_LOG2+1];
	logic              vld_sh [SHININESS_LOG2+1];

	assign sh_s[0] = s_s8;
	assign tail_sh[0] = tail_s8;
	assign vld_sh[0] = vld_s8;

	for (genvar k = 0; k < SHININESS_LOG2; k++) begin : g_pow
		logic [2*SPEC_W-1:0] sq_c;
		assign sq_c = sh_s[k] * sh_s[k];
		always_ff @(posedge clk) begin
			sh_s[k+1] <= (sq_c[2*SPEC_W-1:16] > (2*SPEC_W-16)'(SPEC_CAP)) ? SPEC_CAP
				: sq_c[16 +: SPEC_W];
			tail_sh[k+1] <= tail_sh[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sh[k+1] <= 1'b0;
			end else begin
				vld_sh[k+1] <= vld_sh[k];
			end
		end
	end

	// Stage 9: specular term, half of 255 times the power.
	logic [SP_W-1:0] sp_c;
	logic [SP_W-2:0] spec_s9;
	tail_t           tail_s9, tail_s10, tail_s11;

	assign sp_c = SP_W'(sh_s[SHININESS_LOG2]) * SP_W'(255);

	always_ff @(posedge clk) begin
		spec_s9 <= sp_c[SP_W-1:1];
		tail_s9 <= tail_sh[SHININESS_LOG2];
	end

	// Stage 10: add specular and clip.
	logic [SP_W-1:0] a2_c [3];

	for (genvar i = 0; i < 3; i++) begin : g_a2
		assign a2_c[i] = SP_W'(tail_s9.acc[i]) + SP_W'(spec_s9);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			tail_s10.acc[i] <= (a2_c[i] > SP_W'(CH_MAX)) ? CH_MAX : a2_c[i][ACC_W-1:0];
		end
		tail_s10.bypass <= tail_s9.bypass;
		tail_s10.amb <= tail_s9.amb;
	end

	// Stage 11: apply the lumen gain.
	logic [G_W-1:0] g_s11 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			g_s11[i] <= tail_s10.acc[i] * lumen_gain_q;
		end
		tail_s11 <= tail_s10;
	end

	// Stage 12: apply the light ratio, clip and select the output.
	// The product carries 32 fraction bits, so the integer part starts at bit 32.
	logic [H_W-1:0]    h_c [3];
	logic [CH_W-1:0]   ch_c [3];

	for (genvar i = 0; i < 3; i++) begin : g_out
		assign h_c[i] = g_s11[i] * light_ratio_q;
		assign ch_c[i] = tail_s11.bypass ? tail_s11.amb[i*CH_W +: CH_W]
			: (h_c[i][H_W-1:16] > (H_W-16)'(CH_MAX)) ? CH_MAX[ACC_W-1:16]
			: h_c[i][32 +: CH_W];
	end

	always_ff @(posedge clk) begin
		red_out <= ch_c[0];
		green_out <= ch_c[1];
		blue_out <= ch_c[2];
	end

	// Result strobe and the valid bits of the back end.
	logic vld_s9, vld_s10, vld_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s9 <= vld_sh[SHININESS_LOG2];
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			done <= vld_s11;
		end
	end

endmodule

### hw/rtl/ppls_norm.sv
// Pipelined vector normalize unit: square root then one quotient bit per stage.
module ppls_norm
	import ppls_pkg::*;
(
	input  logic                          clk,
	input  logic [2:0][DIFF_W-1:0]        v_in,
	output logic [2:0][UNIT_W-1:0]        u_out
);

	logic [2:0][DIFF_W-1:0] v_s1, v_s2;
	logic [2:0][SQ_W-1:0]   sq_s1;
	logic [SQ_W-1:0]        sum_s2;

	// Squares of the components, then their sum.
	always_ff @(posedge clk) begin
		v_s1 <= v_in;
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQ_W'($signed(v_in[i]) * $signed(v_in[i]));
		end
		v_s2 <= v_s1;
		sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
	end

	// Integer square root, one result bit per stage.
	logic [SQ_W:0]          rt_x_s [SQRT_STEPS+1];
	logic [SQ_W:0]          rt_r_s [SQRT_STEPS+1];
	logic [2:0][DIFF_W-1:0] rt_v_s [SQRT_STEPS+1];

	assign rt_x_s[0] = {1'b0, sum_s2};
	assign rt_r_s[0] = '0;
	assign rt_v_s[0] = v_s2;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [SQ_W:0] rt_try;
		assign rt_try = rt_r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (rt_x_s[k] >= rt_try) begin
				rt_x_s[k+1] <= rt_x_s[k] - rt_try;
				rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
			end else begin
				rt_x_s[k+1] <= rt_x_s[k];
				rt_r_s[k+1] <= rt_r_s[k] >> 1;
			end
			rt_v_s[k+1] <= rt_v_s[k];
		end
	end

	// Restoring division of |v| * 65536 by the length.
	logic [2:0][LEN_W-1:0]  dv_rem_s [DIV_STEPS+1];
	logic [2:0][DIFF_W-1:0] dv_mag_s [DIV_STEPS+1];
	logic [2:0]             dv_neg_s [DIV_STEPS+1];
	logic [2:0][QUO_W-1:0]  dv_q_s   [DIV_STEPS+1];
	logic [LEN_W-1:0]       dv_len_s [DIV_STEPS+1];

	for (genvar i = 0; i < 3; i++) begin : g_abs
		assign dv_neg_s[0][i] = rt_v_s[SQRT_STEPS][i][DIFF_W-1];
		assign dv_mag_s[0][i] = dv_neg_s[0][i] ? DIFF_W'(-rt_v_s[SQRT_STEPS][i])
			: rt_v_s[SQRT_STEPS][i];
		assign dv_rem_s[0][i] = LEN_W'(dv_mag_s[0][i] >> 1);
		assign dv_q_s[0][i] = '0;
	end
	assign dv_len_s[0] = rt_r_s[SQRT_STEPS][LEN_W-1:0];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int J = DIV_STEPS - 1 - k;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic            nbit;
			logic [LEN_W:0]  trial;
			logic            fits;
			if (J >= UNIT_SHIFT) begin : g_mag_bit
				assign nbit = dv_mag_s[k][i][J-UNIT_SHIFT];
			end else begin : g_zero_bit
				assign nbit = 1'b0;
			end
			assign trial = {dv_rem_s[k][i], nbit};
			assign fits = trial >= {1'b0, dv_len_s[k]};
			always_ff @(posedge clk) begin
				dv_rem_s[k+1][i] <= fits ? LEN_W'(trial - {1'b0, dv_len_s[k]})
					: trial[LEN_W-1:0];
				dv_q_s[k+1][i] <= {dv_q_s[k][i][QUO_W-2:0], fits};
				dv_mag_s[k+1][i] <= dv_mag_s[k][i];
				dv_neg_s[k+1][i] <= dv_neg_s[k][i];
			end
		end
		always_ff @(posedge clk) begin
			dv_len_s[k+1] <= dv_len_s[k];
		end
	end

	// Sign restore; a zero length gives a zero vector.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_len_s[DIV_STEPS] == '0) begin
				u_out[i] <= '0;
			end else if (dv_neg_s[DIV_STEPS][i]) begin
				u_out[i] <= UNIT_W'(-UNIT_W'(dv_q_s[DIV_STEPS][i]));
			end else begin
				u_out[i] <= UNIT_W'(dv_q_s[DIV_STEPS][i]);
			end
		end
	end

endmodule

### hw/rtl/ppls_checker.sv
// Port-level checker for the shader and the bind that attaches it.
`include "assert_macros.svh"

module ppls_checker
	import ppls_pkg::*;
#(
	parameter int SHININESS_LOG2 = SHININESS_LOG2_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               in_shadow,
	input logic [COLOR_W-1:0] ambient_color,
	input logic [CH_W-1:0]    red_out,
	input logic [CH_W-1:0]    green_out,
	input logic [CH_W-1:0]    blue_out
);

	localparam int LAT = pipe_latency(SHININESS_LOG2);
	localparam int AGE_W = $clog2(LAT + 1);

	// Cycles since reset release, saturating at the pipeline latency.
	logic [AGE_W-1:0] age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(LAT)) begin
			age_q <= age_q + AGE_W'(1);
		end
	end

	// The pipeline never pushes back on new items.
	`PPLS_ASSERT_ALWAYS(a_never_busy, !busy)
	// Every result strobe traces back to an item accepted one latency earlier.
	`PPLS_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy, LAT))
	// Every item accepted after reset produces a result one latency later.
	`PPLS_ASSERT_IMPL(a_item_gives_done, (age_q == AGE_W'(LAT)) && $past(start && !busy, LAT), done)
	// A shadowed item returns its ambient color unchanged.
	`PPLS_ASSERT_IMPL(a_shadow_ambient, done && $past(in_shadow, LAT), (red_out == $past(ambient_color[7:0], LAT)) && (green_out == $past(ambient_color[15:8], LAT)) && (blue_out == $past(ambient_color[23:16], LAT)))

endmodule

bind phong_point_light_shader ppls_checker #(.SHININESS_LOG2(SHININESS_LOG2)) u_ppls_checker (.*);

### bench/phong_point_light_shader_tb.sv
// Self-checking testbench of the point-light shader: directed and random items checked against a predictor.
module phong_point_light_shader_tb;
	import ppls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHIN = SHININESS_LOG2_DEF;
	localparam int SETTLE = 80;

	typedef struct {
		logic [VEC_W-1:0] hit;
		logic [VEC_W-1:0] nrm;
		logic [VEC_W-1:0] dir;
		logic [COLOR_W-1:0] col;
		logic [COLOR_W-1:0] amb;
		logic shadow;
	} hit_item_t;

	typedef struct {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pixel_t;

	// Holds the light setting, predicts shaded pixels and checks them in order.
	class shade_scoreboard;
		logic [VEC_W-1:0] light_pos;
		longint ratio;
		longint gain;
		bit enable;
		pixel_t pending[$];
		int errors;

		function new();
			light_pos = '0;
			ratio = 256;
			gain = 256;
			enable = 1;
			errors = 0;
		endfunction

		function automatic void unpack_vec(logic [VEC_W-1:0] w, output longint c[3]);
			for (int i = 0; i < 3; i++)
				c[i] = longint'($signed(w[COMPONENT_WIDTH*i +: COMPONENT_WIDTH]));
		endfunction

		function automatic longint root_floor(longint x);
			longint r;
			longint bitv;
			r = 0;
			bitv = 64'sh4000_0000_0000_0000;
			while (bitv > x)
				bitv = bitv >>> 2;
			while (bitv != 0) begin
				if (x >= r + bitv) begin
					x = x - (r + bitv);
					r = (r >>> 1) + bitv;
				end else begin
					r = r >>> 1;
				end
				bitv = bitv >>> 2;
			end
			return r;
		endfunction

		function automatic void normalize(longint v[3], output longint u[3]);
			longint sq;
			longint len;
			sq = 0;
			for (int i = 0; i < 3; i++)
				sq += v[i] * v[i];
			len = root_floor(sq);
			for (int i = 0; i < 3; i++)
				u[i] = (len == 0) ? 0 : (v[i] * 65536) / len;
		endfunction

		// Notes an accepted item and queues the pixel it should produce.
		function void note_item(hit_item_t it);
			pixel_t px;
			longint lp[3], hp[3], nv[3], dv[3], lv[3], ul[3], vv[3], uv[3], rf[3];
			longint d, s, spec, acc, a, c;
			logic [CH_W-1:0] ch[3];
			if (!enable || it.shadow) begin
				px.r = it.amb[7:0];
				px.g = it.amb[15:8];
				px.b = it.amb[23:16];
				pending.push_back(px);
				return;
			end
			unpack_vec(light_pos, lp);
			unpack_vec(it.hit, hp);
			unpack_vec(it.nrm, nv);
			unpack_vec(it.dir, dv);
			for (int i = 0; i < 3; i++) begin
				lv[i] = lp[i] - hp[i];
				vv[i] = -dv[i];
			end
			normalize(lv, ul);
			normalize(vv, uv);
			d = 0;
			for (int i = 0; i < 3; i++)
				d += ul[i] * nv[i];
			d = d >>> 10;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				rf[i] = -ul[i] + ((2 * d * nv[i]) >>> 10);
				s += uv[i] * rf[i];
			end
			s = s >>> 16;
			if (s < 0) s = 0;
			if (s > (64'sd1 << 24)) s = 64'sd1 << 24;
			for (int k = 0; k < SHIN; k++) begin
				s = (s * s) >>> 16;
				if (s > (64'sd1 << 24)) s = 64'sd1 << 24;
			end
			spec = (255 * s) >>> 1;
			for (int i = 0; i < 3; i++) begin
				a = longint'(it.amb[8*i +: 8]);
				c = longint'(it.col[8*i +: 8]);
				acc = a << 16;
				if (d >= 0) begin
					acc += (c * d * ratio) >>> 8;
					if (acc > (64'sd255 << 16)) acc = 64'sd255 << 16;
				end
				acc += spec;
				if (acc > (64'sd255 << 16)) acc = 64'sd255 << 16;
				acc = (acc * gain * ratio) >>> 16;
				if (acc > (64'sd255 << 16)) acc = 64'sd255 << 16;
				ch[i] = acc[23:16];
			end
			px.r = ch[0];
			px.g = ch[1];
			px.b = ch[2];
			pending.push_back(px);
		endfunction

		// Compares one strobed pixel with the oldest prediction.
		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel %h %h %h", $time, got.r, got.g, got.b);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.r !== want.r) begin
				$display("%0t: red expected %h actual %h", $time, want.r, got.r);
				errors++;
			end
			if (got.g !== want.g) begin
				$display("%0t: green expected %h actual %h", $time, want.g, got.g);
				errors++;
			end
			if (got.b !== want.b) begin
				$display("%0t: blue expected %h actual %h", $time, want.b, got.b);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [VEC_W-1:0] hit_point, surface_normal, view_ray_direction;
	logic [COLOR_W-1:0] surface_color, ambient_color;
	logic in_shadow;
	logic done;
	logic [CH_W-1:0] red_out, green_out, blue_out;

	shade_scoreboard board;

	phong_point_light_shader i_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check every strobed pixel at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			pixel_t px;
			px.r = red_out;
			px.g = green_out;
			px.b = blue_out;
			board.check_pixel(px);
		end
	end

	// Writes one register through the setup and access cycles, then idles the bus.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LIGHT_POSITION: board.light_pos = value[VEC_W-1:0];
			REG_LIGHT_RATIO: board.ratio = longint'(value[RATIO_W-1:0]);
			REG_LUMEN_GAIN: board.gain = longint'(value[GAIN_W-1:0]);
			default: board.enable = value[0];
		endcase
	endtask

	// Waits until every predicted pixel has come, then lets the pipe drain.
	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Presents one item and holds it until accepted, with a random gap before when gaps is set.
	task automatic send_item(hit_item_t it, bit gaps);
		int gap;
		if (gaps) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b1;
		hit_point <= it.hit;
		surface_normal <= it.nrm;
		view_ray_direction <= it.dir;
		surface_color <= it.col;
		ambient_color <= it.amb;
		in_shadow <= it.shadow;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_item(it);
	endtask

	function automatic logic [COMPONENT_WIDTH-1:0] rand_comp(int mode);
		case (mode)
			0: return COMPONENT_WIDTH'($signed($urandom_range(0, 2048)) - 1024);
			1: return COMPONENT_WIDTH'($urandom);
			default: return COMPONENT_WIDTH'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	function automatic logic [VEC_W-1:0] rand_vec(int mode);
		return {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
	endfunction

	// Mostly unit-like normals and modest positions, with full-range noise.
	function automatic hit_item_t rand_item();
		hit_item_t it;
		int mode;
		mode = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(0, 1) * 2;
		it.hit = rand_vec(mode);
		it.nrm = ($urandom_range(0, 3) == 0) ? rand_vec(1) : rand_vec(0);
		it.dir = rand_vec(mode);
		it.col = 24'($urandom);
		it.amb = 24'($urandom);
		it.shadow = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	function automatic hit_item_t make_item(logic [VEC_W-1:0] hp, logic [VEC_W-1:0] nv,
			logic [VEC_W-1:0] dv, logic [COLOR_W-1:0] col, logic [COLOR_W-1:0] amb, logic sh);
		hit_item_t it;
		it.hit = hp;
		it.nrm = nv;
		it.dir = dv;
		it.col = col;
		it.amb = amb;
		it.shadow = sh;
		return it;
	endfunction

	initial begin
		localparam logic [COMPONENT_WIDTH-1:0] ONE = COMPONENT_WIDTH'(1024);
		localparam logic [COMPONENT_WIDTH-1:0] MONE = -COMPONENT_WIDTH'(1024);
		logic [VEC_W-1:0] up, down;
		board = new();
		up = {ONE, {COMPONENT_WIDTH{1'b0}}, {COMPONENT_WIDTH{1'b0}}};
		down = {MONE, {COMPONENT_WIDTH{1'b0}}, {COMPONENT_WIDTH{1'b0}}};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		hit_point = '0;
		surface_normal = '0;
		view_ray_direction = '0;
		surface_color = '0;
		ambient_color = '0;
		in_shadow = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset settings: light at the origin.
		send_item(make_item('0, up, down, 24'hFFFFFF, 24'h000000, 1'b0), 1'b0);
		send_item(make_item(down, up, down, 24'hFFFFFF, 24'hFFFFFF, 1'b0), 1'b0);
		send_item(make_item(down, up, down, 24'h804020, 24'h102030, 1'b1), 1'b0);
		send_item(make_item(down, up, '0, 24'h0000FF, 24'h000000, 1'b0), 1'b0);
		send_item(make_item(up, up, down, 24'hFFFFFF, 24'h010203, 1'b0), 1'b0);
		send_item(make_item({VEC_W{1'b1}}, {VEC_W{1'b1}}, {VEC_W{1'b1}},
			24'hFFFFFF, 24'hFFFFFF, 1'b0), 1'b0);
		send_item(make_item({1'b0, {(VEC_W-1){1'b1}}}, up, {1'b0, {(VEC_W-1){1'b1}}},
			24'h55AA55, 24'hAA55AA, 1'b0), 1'b0);
		send_item(make_item(down, rand_vec(1), down, 24'hFFFFFF, 24'h000000, 1'b0), 1'b0);
		drain();

		// Extreme settings, then light disabled.
		write_reg(REG_LIGHT_POSITION, {1'b0, {(VEC_W-1){1'b1}}});
		write_reg(REG_LIGHT_RATIO, 64'd511);
		write_reg(REG_LUMEN_GAIN, 64'hFFFF);
		for (int i = 0; i < 6; i++)
			send_item(rand_item(), 1'b0);
		send_item(make_item(down, up, down, 24'h000000, 24'h000000, 1'b0), 1'b0);
		drain();
		write_reg(REG_LIGHT_RATIO, 64'd0);
		write_reg(REG_LUMEN_GAIN, 64'd0);
		write_reg(REG_LIGHT_POSITION, up);
		send_item(make_item(down, up, down, 24'hFFFFFF, 24'h123456, 1'b0), 1'b0);
		send_item(make_item(up, up, down, 24'hFFFFFF, 24'h123456, 1'b0), 1'b0);
		drain();
		write_reg(REG_LIGHT_ENABLE, 64'd0);
		send_item(make_item(down, up, down, 24'hFFFFFF, 24'hFEDCBA, 1'b0), 1'b0);
		send_item(make_item(down, up, down, 24'hFFFFFF, 24'hABCDEF, 1'b1), 1'b0);
		drain();

		// Random phases, each under its own light setting.
		for (int ph = 0; ph < 9; ph++) begin
			write_reg(REG_LIGHT_ENABLE, (ph % 4 == 3) ? 64'd0 : 64'd1);
			write_reg(REG_LIGHT_POSITION, ($urandom_range(0, 1) == 0)
				? 64'(rand_vec(0)) : 64'(rand_vec(1)));
			write_reg(REG_LIGHT_RATIO, ($urandom_range(0, 2) == 0)
				? 64'($urandom_range(0, 511)) : 64'($urandom_range(128, 256)));
			write_reg(REG_LUMEN_GAIN, ($urandom_range(0, 2) == 0)
				? 64'($urandom_range(0, 65535)) : 64'($urandom_range(128, 512)));
			for (int n = 0; n < 200; n++)
				send_item(rand_item(), (ph % 3) != 1);
			drain();
		end

		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ppls_pkg.sv
hw/rtl/ppls_norm.sv
hw/rtl/phong_point_light_shader.sv
hw/rtl/ppls_checker.sv
bench/phong_point_light_shader_tb.sv
